@@ hdl/lqrs_pkg.sv @@
// shared types and constants for the linear and quadratic root solver
package lqrs_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    // result classification codes
    typedef enum logic [2:0] {
        KIND_LIN = 3'd0,
        KIND_TWO = 3'd1,
        KIND_DBL = 3'd2,
        KIND_CPX = 3'd3,
        KIND_ERR = 3'd4
    } kind_t;

    typedef struct packed {
        logic                         func;
        logic signed [DATA_WIDTH-1:0] coef_a;
        logic signed [DATA_WIDTH-1:0] coef_b;
        logic signed [DATA_WIDTH-1:0] coef_c;
    } in_word_t;

    typedef struct packed {
        logic [2:0]                   root_kind;
        logic signed [DATA_WIDTH-1:0] root_one;
        logic signed [DATA_WIDTH-1:0] root_two;
        logic                         overflow;
    } out_word_t;

endpackage

@@ hdl/linear_quadratic_root_solver.sv @@
// Pipeline at Q16.16: product, discriminant, one square root bit per stage, numerator setup,
// one quotient bit per divider stage, output register.
// Throughput: one word per cycle; the whole pipeline holds while the output word stalls.
// The divider chain of DATA_WIDTH+2+FRAC_BITS stages sets the depth.
// Reset (rst_n low, asynchronous) clears every stage, so no word is valid after reset.
module linear_quadratic_root_solver #(
    parameter int FRAC_BITS = lqrs_pkg::FRAC_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  lqrs_pkg::in_word_t  in_word,
    output logic                in_stall,
    output logic                out_valid,
    output lqrs_pkg::out_word_t out_word,
    input  logic                out_stall
);
    import lqrs_pkg::*;

    localparam int DW   = DATA_WIDTH;
    localparam int SW   = DW + 1;          // square root width
    localparam int RW   = SW + 2;          // square root remainder width
    localparam int NW   = DW + 3;          // signed numerator width
    localparam int NMW  = DW + 2;          // numerator magnitude width
    localparam int DENW = DW + 1;          // divisor width
    localparam int QW   = NMW + FRAC_BITS; // quotient width

    typedef struct packed {
        kind_t                kind;
        logic                 aneg;
        logic [DW-1:0]        amag;
        logic signed [DW-1:0] b;
        logic signed [DW:0]   cmb;
    } ctx_t;

    typedef struct packed {
        logic                 vld;
        logic                 func;
        logic                 azero;
        logic                 aneg;
        logic                 cneg;
        logic                 czero;
        logic [DW-1:0]        amag;
        logic signed [DW-1:0] b;
        logic signed [DW:0]   cmb;
        logic [2*DW-1:0]      bb;
        logic [2*DW-1:0]      ac;
    } prod_t;

    typedef struct packed {
        logic            vld;
        ctx_t            ctx;
        logic [2*SW-1:0] rad;
        logic [RW-1:0]   rem;
        logic [SW-1:0]   root;
    } sq_t;

    typedef struct packed {
        logic            vld;
        kind_t           kind;
        logic            neg1;
        logic            neg2;
        logic [DENW-1:0] den;
        logic [QW-1:0]   d1;
        logic [DENW-1:0] r1;
        logic [QW-1:0]   q1;
        logic [QW-1:0]   d2;
        logic [DENW-1:0] r2;
        logic [QW-1:0]   q2;
    } dv_t;

    logic en;
    prod_t p1_reg, p1_next;
    sq_t   sq_reg  [0:SW];
    sq_t   sq_next [0:SW];
    dv_t   dv_reg  [0:QW];
    dv_t   dv_next [0:QW];
    logic      out_valid_reg, out_valid_next;
    out_word_t out_reg, out_next;

    // pipeline advances unless the output word is held
    assign en        = !(out_valid_reg && out_stall);
    assign in_stall  = !en;
    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    // stage 1: magnitudes and products
    always_comb
    begin
        logic [DW-1:0] bmag;
        logic [DW-1:0] cmag;
        bmag = in_word.coef_b[DW-1] ? DW'(-in_word.coef_b) : DW'(in_word.coef_b);
        cmag = in_word.coef_c[DW-1] ? DW'(-in_word.coef_c) : DW'(in_word.coef_c);
        p1_next.vld   = in_valid;
        p1_next.func  = in_word.func;
        p1_next.azero = (in_word.coef_a == '0);
        p1_next.aneg  = in_word.coef_a[DW-1];
        p1_next.cneg  = in_word.coef_c[DW-1];
        p1_next.czero = (in_word.coef_c == '0);
        p1_next.amag  = in_word.coef_a[DW-1] ? DW'(-in_word.coef_a) : DW'(in_word.coef_a);
        p1_next.b     = in_word.coef_b;
        p1_next.cmb   = (DW+1)'(in_word.coef_c) - (DW+1)'(in_word.coef_b);
        p1_next.bb    = bmag * bmag;
        p1_next.ac    = p1_next.amag * cmag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p1_reg <= '0;
        else if (en)
            p1_reg <= p1_next;
    end

    // stage 2: discriminant magnitude and sign, root kind
    always_comb
    begin
        logic [2*SW-1:0] bbx;
        logic [2*SW-1:0] ac4;
        logic            acneg;
        logic            gt;
        logic            eq;
        bbx   = (2*SW)'(p1_reg.bb);
        ac4   = {p1_reg.ac, 2'b00};
        acneg = (p1_reg.aneg != p1_reg.cneg) && !p1_reg.czero;
        gt    = acneg || (bbx > ac4);
        eq    = !acneg && (bbx == ac4);
        sq_next[0].vld      = p1_reg.vld;
        sq_next[0].ctx.aneg = p1_reg.aneg;
        sq_next[0].ctx.amag = p1_reg.amag;
        sq_next[0].ctx.b    = p1_reg.b;
        sq_next[0].ctx.cmb  = p1_reg.cmb;
        sq_next[0].rem      = '0;
        sq_next[0].root     = '0;
        if (acneg)
            sq_next[0].rad = bbx + ac4;
        else if (gt)
            sq_next[0].rad = bbx - ac4;
        else
            sq_next[0].rad = ac4 - bbx;
        if (p1_reg.azero)
            sq_next[0].ctx.kind = KIND_ERR;
        else if (!p1_reg.func)
            sq_next[0].ctx.kind = KIND_LIN;
        else if (gt)
            sq_next[0].ctx.kind = KIND_TWO;
        else if (eq)
            sq_next[0].ctx.kind = KIND_DBL;
        else
            sq_next[0].ctx.kind = KIND_CPX;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_reg[0] <= '0;
        else if (en)
            sq_reg[0] <= sq_next[0];
    end

    // square root, one result bit per stage
    for (genvar i = 1; i <= SW; i++)
    begin : g_sqrt
        always_comb
        begin
            logic [RW-1:0] r;
            logic [RW-1:0] trial;
            r     = {sq_reg[i-1].rem[RW-3:0], sq_reg[i-1].rad[2*SW-1:2*SW-2]};
            trial = {sq_reg[i-1].root, 2'b01};
            sq_next[i]     = sq_reg[i-1];
            sq_next[i].rad = {sq_reg[i-1].rad[2*SW-3:0], 2'b00};
            if (r >= trial)
            begin
                sq_next[i].rem  = r - trial;
                sq_next[i].root = {sq_reg[i-1].root[SW-2:0], 1'b1};
            end
            else
            begin
                sq_next[i].rem  = r;
                sq_next[i].root = {sq_reg[i-1].root[SW-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_reg[i] <= '0;
            else if (en)
                sq_reg[i] <= sq_next[i];
        end
    end

    // numerators, signs and divisor
    always_comb
    begin
        logic signed [NW-1:0] bx;
        logic signed [NW-1:0] sv;
        logic signed [NW-1:0] n1;
        logic signed [NW-1:0] n2;
        logic                 dneg2;
        logic [NMW-1:0]       m1;
        logic [NMW-1:0]       m2;
        ctx_t                 cx;
        cx    = sq_reg[SW].ctx;
        bx    = NW'(cx.b);
        sv    = NW'($signed({1'b0, sq_reg[SW].root}));
        dneg2 = cx.aneg;
        dv_next[0].den = {cx.amag, 1'b0};
        case (cx.kind)
            KIND_LIN:
            begin
                n1 = NW'(cx.cmb);
                n2 = '0;
                dv_next[0].den = {1'b0, cx.amag};
            end
            KIND_TWO:
            begin
                n1 = sv - bx;
                n2 = -bx - sv;
            end
            KIND_CPX:
            begin
                n1    = -bx;
                n2    = sv;
                dneg2 = 1'b0;
            end
            default:
            begin
                n1 = -bx;
                n2 = -bx;
            end
        endcase
        m1 = n1[NW-1] ? NMW'(-n1) : NMW'(n1);
        m2 = n2[NW-1] ? NMW'(-n2) : NMW'(n2);
        dv_next[0].vld  = sq_reg[SW].vld;
        dv_next[0].kind = cx.kind;
        dv_next[0].neg1 = n1[NW-1] ^ cx.aneg;
        dv_next[0].neg2 = n2[NW-1] ^ dneg2;
        dv_next[0].d1   = {m1, {FRAC_BITS{1'b0}}};
        dv_next[0].d2   = {m2, {FRAC_BITS{1'b0}}};
        dv_next[0].r1   = '0;
        dv_next[0].r2   = '0;
        dv_next[0].q1   = '0;
        dv_next[0].q2   = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_reg[0] <= '0;
        else if (en)
            dv_reg[0] <= dv_next[0];
    end

    // two restoring dividers, one quotient bit per stage
    for (genvar j = 1; j <= QW; j++)
    begin : g_div
        always_comb
        begin
            logic [DENW:0] t1;
            logic [DENW:0] t2;
            logic [DENW:0] dx;
            logic [DENW:0] s1;
            logic [DENW:0] s2;
            logic          ge1;
            logic          ge2;
            dx  = {1'b0, dv_reg[j-1].den};
            t1  = {dv_reg[j-1].r1, dv_reg[j-1].d1[QW-1]};
            t2  = {dv_reg[j-1].r2, dv_reg[j-1].d2[QW-1]};
            ge1 = (t1 >= dx);
            ge2 = (t2 >= dx);
            s1  = ge1 ? t1 - dx : t1;
            s2  = ge2 ? t2 - dx : t2;
            dv_next[j]    = dv_reg[j-1];
            dv_next[j].r1 = s1[DENW-1:0];
            dv_next[j].r2 = s2[DENW-1:0];
            dv_next[j].d1 = {dv_reg[j-1].d1[QW-2:0], 1'b0};
            dv_next[j].d2 = {dv_reg[j-1].d2[QW-2:0], 1'b0};
            dv_next[j].q1 = {dv_reg[j-1].q1[QW-2:0], ge1};
            dv_next[j].q2 = {dv_reg[j-1].q2[QW-2:0], ge2};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_reg[j] <= '0;
            else if (en)
                dv_reg[j] <= dv_next[j];
        end
    end

    // saturate a quotient magnitude and apply sign; msb of result is the overflow
    function automatic logic [DW:0] sat_q(input logic [QW-1:0] q, input logic neg);
        logic          big;
        logic [DW-1:0] lim;
        logic [DW-1:0] mag;
        big = (|q[QW-1:DW]) || (q[DW-1] && (!neg || (|q[DW-2:0])));
        lim = neg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        mag = big ? lim : q[DW-1:0];
        return {big, neg ? -mag : mag};
    endfunction

    // output word
    always_comb
    begin
        logic [DW:0] v1;
        logic [DW:0] v2;
        v1 = sat_q(dv_reg[QW].q1, dv_reg[QW].neg1);
        v2 = sat_q(dv_reg[QW].q2, dv_reg[QW].neg2);
        out_valid_next     = dv_reg[QW].vld;
        out_next.root_kind = dv_reg[QW].kind;
        case (dv_reg[QW].kind)
            KIND_LIN:
            begin
                out_next.root_one = v1[DW-1:0];
                out_next.root_two = '0;
                out_next.overflow = v1[DW];
            end
            KIND_DBL:
            begin
                out_next.root_one = v1[DW-1:0];
                out_next.root_two = v1[DW-1:0];
                out_next.overflow = v1[DW];
            end
            KIND_TWO, KIND_CPX:
            begin
                out_next.root_one = v1[DW-1:0];
                out_next.root_two = v2[DW-1:0];
                out_next.overflow = v1[DW] | v2[DW];
            end
            default:
            begin
                out_next.root_one = '0;
                out_next.root_two = '0;
                out_next.overflow = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else if (en)
        begin
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

endmodule
